FILE: hw/rtl/kmst_pkg.sv
// kmst_pkg: shared constants, codes and the sequencer state type for the
// kruskal spanning tree unit; no dependencies
package kmst_pkg;

  localparam int MAX_EDGES_DEF    = 256;
  localparam int MAX_VERTICES_DEF = 64;
  localparam int LENGTH_BITS_DEF  = 32;
  localparam int MAX_RESULTS      = 64;

  localparam int CMD_W    = 2;
  localparam int END_W    = 6;
  localparam int LEN_W    = 32;
  localparam int CNT_W    = 6;
  localparam int STATUS_W = 2;
  localparam int VCNT_W   = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } kmst_cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_TREE_EDGE = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_OUT_EDGES = 2'd2,
    ST_FULL      = 2'd3
  } kmst_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GAP_UP,
    S_GAP_DOWN,
    S_PASS_RD,
    S_PASS_T,
    S_CMP_RD,
    S_CMP,
    S_SCAN_INIT,
    S_SCAN_RD,
    S_SCAN_EDGE,
    S_FIND_RD,
    S_FIND_CK,
    S_UNITE,
    S_EMIT
  } kmst_state_t;

endpackage

FILE: hw/rtl/kmst_if.sv
// kmst_if: valid/ready channel interfaces for input, result and config
// depends on kmst_pkg
interface kmst_in_if
  import kmst_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [END_W-1:0] end_a;
  logic [END_W-1:0] end_b;
  logic [LEN_W-1:0] length;
  modport source (output valid, cmd, end_a, end_b, length, input ready);
  modport sink   (input valid, cmd, end_a, end_b, length, output ready);
endinterface

interface kmst_out_if
  import kmst_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [END_W-1:0]    tree_end_a;
  logic [END_W-1:0]    tree_end_b;
  logic [LEN_W-1:0]    tree_length;
  logic [CNT_W-1:0]    tree_count;
  logic [STATUS_W-1:0] status;
  logic                last;
  modport source (output valid, tree_end_a, tree_end_b, tree_length, tree_count,
                  status, last, input ready);
  modport sink   (input valid, tree_end_a, tree_end_b, tree_length, tree_count,
                  status, last, output ready);
endinterface

interface kmst_cfg_if
  import kmst_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [VCNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: hw/rtl/kruskal_minimum_spanning_tree_unit.sv
// kruskal_minimum_spanning_tree_unit: edge store, shell sort and union-find
// scan under one sequencer; depends on kmst_pkg and kmst_if
//
//  channel  | dir | moves
//  in_if    | in  | cmd, end_a, end_b, length (load / run / clear)
//  out_if   | out | tree edge, count, status, last
//  cfg_if   | in  | vertex_count
//
// a full-store load gives one result.
// run: shell sort over the edge memory (one read, one write port): gap
// steps, then per element of a pass a read plus a compare and move per
// gap hop; then per edge a read, two finds walking parent hops, unite;
// an edge with an end off the table is skipped; each tree edge is emitted.
// rst_n is synchronous; it clears control, count and parent valid bits.
// in_if is not ready during a run; out_if stalls hold the sequencer.
module kruskal_minimum_spanning_tree_unit
  import kmst_pkg::*;
#(
  parameter int MAX_EDGES    = MAX_EDGES_DEF,
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int LENGTH_BITS  = LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  kmst_in_if.sink    in_if,
  kmst_out_if.source out_if,
  kmst_cfg_if.sink   cfg_if
);

  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int HW = CW + 2;
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int KW = $clog2(MAX_VERTICES);
  localparam int EW = 2 * END_W + LENGTH_BITS;
  localparam int RW = $clog2(MAX_RESULTS + 1);

  // edge memory
  logic [EW-1:0] edge_mem [MAX_EDGES];
  logic [EW-1:0] erd_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [EW-1:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      edge_mem[mem_wa] <= mem_wd;
    end
    erd_r <= edge_mem[mem_ra];
  end

  // parent table; entries without a valid bit read as their own index
  logic [VW-1:0]           par_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] pvld_r;
  logic [VW-1:0]           prd_r, pidx_r;
  logic                    prdv_r;
  logic                    par_we, par_clr;
  logic [VW-1:0]           par_wa, par_wd, par_ra;

  always_ff @(posedge clk) begin
    if (par_we) begin
      par_mem[par_wa] <= par_wd;
    end
    prd_r  <= par_mem[par_ra];
    prdv_r <= pvld_r[par_ra];
    pidx_r <= par_ra;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || par_clr) begin
      pvld_r <= '0;
    end else if (par_we) begin
      pvld_r[par_wa] <= 1'b1;
    end
  end

  logic [VW-1:0] p_eff;
  assign p_eff = prdv_r ? prd_r : pidx_r;

  // control registers
  kmst_state_t       state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [VCNT_W-1:0] vcount_r;
  logic [HW-1:0]     h_r, h_nxt, g_r, g_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [EW-1:0]     t_r, t_nxt, e_r, e_nxt;
  logic [VCNT_W-1:0] comps_r, comps_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [RW-1:0]     nres_r, nres_nxt;
  logic [VW-1:0]     v_r, v_nxt, r1_r, r1_nxt, r2_r, r2_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic              side_r, side_nxt;
  logic              done_r, done_nxt;

  // output register and pending result
  logic                ov_r, ov_nxt;
  logic [END_W-1:0]    oa_r, oa_nxt, ob_r, ob_nxt;
  logic [LEN_W-1:0]    ol_r, ol_nxt;
  logic [CNT_W-1:0]    oc_r, oc_nxt;
  logic [STATUS_W-1:0] os_r, os_nxt;
  logic                olast_r, olast_nxt;
  logic [END_W-1:0]    pa_r, pa_nxt, pb_r, pb_nxt;
  logic [LEN_W-1:0]    pl_r, pl_nxt;
  logic [CNT_W-1:0]    pc_r, pc_nxt;
  logic [STATUS_W-1:0] ps_r, ps_nxt;

  logic out_free, in_acc;
  assign out_free = !ov_r || out_if.ready;
  assign in_if.ready = (state_r == S_IDLE) && out_free;
  assign in_acc = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  assign out_if.valid       = ov_r;
  assign out_if.tree_end_a  = oa_r;
  assign out_if.tree_end_b  = ob_r;
  assign out_if.tree_length = ol_r;
  assign out_if.tree_count  = oc_r;
  assign out_if.status      = os_r;
  assign out_if.last        = olast_r;

  // field views
  logic [63:0]          in_len64, t_len64, e_len64, rd_len64, hx3, gx3;
  logic [LENGTH_BITS-1:0] rd_len, t_len;
  logic [END_W-1:0]     e_a, e_b;
  logic [HW-1:0]        n_h;

  assign in_len64 = {32'd0, in_if.length};
  assign rd_len   = erd_r[LENGTH_BITS-1:0];
  assign t_len    = t_r[LENGTH_BITS-1:0];
  assign e_a      = e_r[EW-1 -: END_W];
  assign e_b      = e_r[EW-END_W-1 -: END_W];
  assign e_len64  = 64'(e_r[LENGTH_BITS-1:0]);
  assign t_len64  = 64'(t_len);
  assign rd_len64 = 64'(rd_len);
  assign n_h      = HW'(count_r);
  assign hx3      = 64'(h_r) * 64'd3 + 64'd1;
  assign gx3      = 64'(g_r) * 64'd3 + 64'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      vcount_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        vcount_r <= cfg_if.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    h_r <= h_nxt;  g_r <= g_nxt;  i_r <= i_nxt;  j_r <= j_nxt;
    t_r <= t_nxt;  e_r <= e_nxt;
    comps_r <= comps_nxt;  cnt_r <= cnt_nxt;  nres_r <= nres_nxt;
    v_r <= v_nxt;  r1_r <= r1_nxt;  r2_r <= r2_nxt;  k_r <= k_nxt;
    side_r <= side_nxt;  done_r <= done_nxt;
    oa_r <= oa_nxt;  ob_r <= ob_nxt;  ol_r <= ol_nxt;  oc_r <= oc_nxt;
    os_r <= os_nxt;  olast_r <= olast_nxt;
    pa_r <= pa_nxt;  pb_r <= pb_nxt;  pl_r <= pl_nxt;  pc_r <= pc_nxt;
    ps_r <= ps_nxt;
  end

  always_comb begin
    state_nxt = state_r;  count_nxt = count_r;
    h_nxt = h_r;  g_nxt = g_r;  i_nxt = i_r;  j_nxt = j_r;
    t_nxt = t_r;  e_nxt = e_r;
    comps_nxt = comps_r;  cnt_nxt = cnt_r;  nres_nxt = nres_r;
    v_nxt = v_r;  r1_nxt = r1_r;  r2_nxt = r2_r;  k_nxt = k_r;
    side_nxt = side_r;  done_nxt = done_r;
    ov_nxt = ov_r && !out_if.ready;
    oa_nxt = oa_r;  ob_nxt = ob_r;  ol_nxt = ol_r;  oc_nxt = oc_r;
    os_nxt = os_r;  olast_nxt = olast_r;
    pa_nxt = pa_r;  pb_nxt = pb_r;  pl_nxt = pl_r;  pc_nxt = pc_r;
    ps_nxt = ps_r;
    mem_we = 1'b0;  mem_wa = count_r[AW-1:0];  mem_ra = i_r[AW-1:0];
    mem_wd = {in_if.end_a, in_if.end_b, in_len64[LENGTH_BITS-1:0]};
    par_we = 1'b0;  par_clr = 1'b0;  par_wa = r1_r;  par_wd = r2_r;
    par_ra = v_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_if.cmd)
            CMD_LOAD: begin
              if (count_r == CW'(MAX_EDGES)) begin
                ov_nxt = 1'b1;  oa_nxt = '0;  ob_nxt = '0;  ol_nxt = '0;
                oc_nxt = '0;  os_nxt = ST_FULL;  olast_nxt = 1'b0;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_RUN: begin
              h_nxt = HW'(1);
              state_nxt = (count_r < CW'(2)) ? S_SCAN_INIT : S_GAP_UP;
            end
            CMD_CLEAR: count_nxt = '0;
            default: ;
          endcase
        end
      end
      // first gap above the edge count
      S_GAP_UP: begin
        if (h_r <= n_h) begin
          h_nxt = hx3[HW-1:0];
        end else begin
          g_nxt = HW'(1);
          state_nxt = S_GAP_DOWN;
        end
      end
      // h / 3 found by stepping the gap sequence up to just below h
      S_GAP_DOWN: begin
        if (gx3 < 64'(h_r)) begin
          g_nxt = gx3[HW-1:0];
        end else begin
          h_nxt = g_r;
          i_nxt = g_r;
          state_nxt = S_PASS_RD;
        end
      end
      S_PASS_RD: begin
        mem_ra = i_r[AW-1:0];
        if (i_r >= n_h) begin
          if (h_r > HW'(1)) begin
            g_nxt = HW'(1);
            state_nxt = S_GAP_DOWN;
          end else begin
            state_nxt = S_SCAN_INIT;
          end
        end else begin
          state_nxt = S_PASS_T;
        end
      end
      S_PASS_T: begin
        t_nxt = erd_r;
        j_nxt = i_r;
        state_nxt = S_CMP_RD;
      end
      S_CMP_RD: begin
        mem_ra = AW'(j_r - h_r);
        if (j_r >= h_r) begin
          state_nxt = S_CMP;
        end else begin
          mem_we = 1'b1;  mem_wa = j_r[AW-1:0];  mem_wd = t_r;
          i_nxt = i_r + 1'b1;
          state_nxt = S_PASS_RD;
        end
      end
      S_CMP: begin
        mem_we = 1'b1;  mem_wa = j_r[AW-1:0];
        if (rd_len64 <= t_len64) begin
          mem_wd = t_r;
          i_nxt = i_r + 1'b1;
          state_nxt = S_PASS_RD;
        end else begin
          mem_wd = erd_r;
          j_nxt = j_r - h_r;
          state_nxt = S_CMP_RD;
        end
      end
      S_SCAN_INIT: begin
        par_clr = 1'b1;
        comps_nxt = vcount_r;
        cnt_nxt = '0;  nres_nxt = '0;  i_nxt = '0;
        if (vcount_r <= VCNT_W'(1)) begin
          pa_nxt = '0;  pb_nxt = '0;  pl_nxt = '0;  pc_nxt = '0;
          ps_nxt = ST_EMPTY;  done_nxt = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        mem_ra = i_r[AW-1:0];
        if (i_r >= n_h || nres_r >= RW'(MAX_RESULTS - 1)) begin
          pa_nxt = '0;  pb_nxt = '0;  pl_nxt = '0;  pc_nxt = cnt_r;
          ps_nxt = ST_OUT_EDGES;  done_nxt = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_SCAN_EDGE;
        end
      end
      S_SCAN_EDGE: begin
        e_nxt = erd_r;
        i_nxt = i_r + 1'b1;
        if ({2'b00, erd_r[EW-1 -: END_W]} >= 8'(MAX_VERTICES) ||
            {2'b00, erd_r[EW-END_W-1 -: END_W]} >= 8'(MAX_VERTICES)) begin
          state_nxt = S_SCAN_RD;
        end else begin
          v_nxt = VW'(erd_r[EW-1 -: END_W]);
          k_nxt = '0;
          side_nxt = 1'b0;
          state_nxt = S_FIND_RD;
        end
      end
      S_FIND_RD: begin
        par_ra = v_r;
        state_nxt = S_FIND_CK;
      end
      S_FIND_CK: begin
        if (p_eff == v_r || 32'(p_eff) >= 32'(MAX_VERTICES) ||
            32'(k_r) == 32'(MAX_VERTICES - 1)) begin
          if (!side_r) begin
            r1_nxt = (p_eff == v_r || 32'(p_eff) >= 32'(MAX_VERTICES)) ? v_r : p_eff;
            v_nxt = VW'(e_b);
            k_nxt = '0;
            side_nxt = 1'b1;
            state_nxt = S_FIND_RD;
          end else begin
            r2_nxt = (p_eff == v_r || 32'(p_eff) >= 32'(MAX_VERTICES)) ? v_r : p_eff;
            state_nxt = S_UNITE;
          end
        end else begin
          v_nxt = p_eff;
          k_nxt = k_r + 1'b1;
          state_nxt = S_FIND_RD;
        end
      end
      S_UNITE: begin
        if (r1_r != r2_r) begin
          par_we = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          comps_nxt = comps_r - 1'b1;
          nres_nxt = nres_r + 1'b1;
          pa_nxt = e_a;  pb_nxt = e_b;
          pl_nxt = e_len64[LEN_W-1:0];
          pc_nxt = cnt_r + 1'b1;
          ps_nxt = ST_TREE_EDGE;
          done_nxt = (comps_r - 1'b1) <= VCNT_W'(1);
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          oa_nxt = pa_r;  ob_nxt = pb_r;  ol_nxt = pl_r;  oc_nxt = pc_r;
          os_nxt = ps_r;  olast_nxt = done_r;
          state_nxt = done_r ? S_IDLE : S_SCAN_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_if.ready)
    else $error("input taken during a run");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_EDGES))
    else $error("edge count past store size");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_if.cmd == CMD_LOAD && count_r == CW'(MAX_EDGES) |=>
      ov_r && os_r == ST_FULL && !olast_r && count_r == CW'(MAX_EDGES))
    else $error("store-full load not flagged");

  a_emit_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && out_free && done_r |=> state_r == S_IDLE && olast_r)
    else $error("final result without last");

endmodule

FILE: bench/kruskal_minimum_spanning_tree_unit_test.sv
// kruskal_minimum_spanning_tree_unit_test: self-checking bench for the kruskal unit,
// predicting tree edges per run; depends on kmst_pkg, kmst_if and the unit's rtl
`timescale 1ns / 1ps

module kruskal_minimum_spanning_tree_unit_test;
  import kmst_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    kmst_cmd_t   cmd;
    logic [5:0]  a;
    logic [5:0]  b;
    logic [31:0] len;
    bit          hold;
  } edge_cmd_t;

  typedef struct {
    logic [5:0]  a;
    logic [5:0]  b;
    logic [31:0] len;
  } arc_t;

  typedef struct {
    logic [5:0]   a;
    logic [5:0]   b;
    logic [31:0]  len;
    logic [5:0]   cnt;
    kmst_status_t status;
    logic         last;
  } tree_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  kmst_in_if  in_if ();
  kmst_out_if out_if ();
  kmst_cfg_if cfg_if ();

  kruskal_minimum_spanning_tree_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if.sink),
    .out_if(out_if.source),
    .cfg_if(cfg_if.sink)
  );

  always #5 clk = ~clk;

  edge_cmd_t    pending_cmds[$];
  tree_result_t tree_results_due[$];
  arc_t         arc_mem[MAX_EDGES_DEF];
  int           arc_count = 0;
  int           vertex_total = 0;
  int           fails = 0;
  int           cycles = 0;
  int           idle_mode = 0;  // 0 none, 1 sender, 2 receiver, 3 both
  bit           cmd_taken = 1'b0;

  function automatic void push_result(logic [5:0] a, logic [5:0] b, logic [31:0] len,
                                      int cnt, kmst_status_t st, bit last);
    tree_result_t r;
    r.a = a; r.b = b; r.len = len; r.cnt = cnt[5:0]; r.status = st; r.last = last;
    tree_results_due.push_back(r);
  endfunction

  function automatic int root_of(ref int parent[64], input int v);
    int p;
    for (int k = 0; k < 64; k++) begin
      p = parent[v];
      if (p == v || p >= 64) break;
      v = p;
    end
    return v;
  endfunction

  // sort in place (persists), then union-find scan
  function automatic void kruskal_predict();
    int   h, j, comps, cnt, nres, idx, r1, r2;
    int   parent[64];
    arc_t t;
    h = 1;
    if (arc_count >= 2) begin
      while (h <= arc_count) h = 3 * h + 1;
      do begin
        h = h / 3;
        for (int i = h; i < arc_count; i++) begin
          t = arc_mem[i];
          j = i;
          while (j >= h && arc_mem[j-h].len > t.len) begin
            arc_mem[j] = arc_mem[j-h];
            j -= h;
          end
          arc_mem[j] = t;
        end
      end while (h > 1);
    end
    for (int v = 0; v < 64; v++) parent[v] = v;
    comps = vertex_total;
    if (comps <= 1) begin
      push_result(0, 0, 0, 0, ST_EMPTY, 1'b1);
      return;
    end
    cnt = 0; nres = 0; idx = 0;
    while (comps > 1) begin
      if (idx >= arc_count || nres >= MAX_RESULTS - 1) begin
        push_result(0, 0, 0, cnt, ST_OUT_EDGES, 1'b1);
        return;
      end
      t = arc_mem[idx];
      idx++;
      r1 = root_of(parent, t.a);
      r2 = root_of(parent, t.b);
      if (r1 != r2) begin
        parent[r1] = r2;
        cnt++;
        comps--;
        push_result(t.a, t.b, t.len, cnt, ST_TREE_EDGE, comps <= 1);
        nres++;
      end
    end
  endfunction

  function automatic void apply_cmd(edge_cmd_t c);
    case (c.cmd)
      CMD_LOAD: begin
        if (arc_count >= MAX_EDGES_DEF) push_result(0, 0, 0, 0, ST_FULL, 1'b0);
        else begin
          arc_mem[arc_count] = '{a: c.a, b: c.b, len: c.len};
          arc_count++;
        end
      end
      CMD_CLEAR: arc_count = 0;
      CMD_RUN:   kruskal_predict();
      default: ;
    endcase
  endfunction

  // input driver: accept at rising edge, present at falling edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("kruskal_minimum_spanning_tree_unit_test NOT OK");
      $finish;
    end
    if (rst_n && in_if.valid && in_if.ready) begin
      apply_cmd(pending_cmds.pop_front());
      cmd_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || cmd_taken) begin
      cmd_taken = 1'b0;
      if (pending_cmds.size() > 0 && !(pending_cmds[0].hold && tree_results_due.size() > 0)
          && !((idle_mode == 1 && $urandom_range(99) < 83) ||
               (idle_mode == 3 && $urandom_range(99) < 13))) begin
        in_if.valid  <= 1'b1;
        in_if.cmd    <= pending_cmds[0].cmd;
        in_if.end_a  <= pending_cmds[0].a;
        in_if.end_b  <= pending_cmds[0].b;
        in_if.length <= pending_cmds[0].len;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
    out_if.ready <= rst_n && !((idle_mode == 2 && $urandom_range(99) < 83) ||
                               (idle_mode == 3 && $urandom_range(99) < 13));
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s expected %0h got %0h", name, want, got);
      fails++;
    end
  endfunction

  // result monitor
  always @(posedge clk) begin
    tree_result_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (tree_results_due.size() == 0) begin
        $error("unexpected result transaction status %0d", out_if.status);
        fails++;
      end else begin
        e = tree_results_due.pop_front();
        check_field("tree_end_a", e.a, out_if.tree_end_a);
        check_field("tree_end_b", e.b, out_if.tree_end_b);
        check_field("tree_length", e.len, out_if.tree_length);
        check_field("tree_count", e.cnt, out_if.tree_count);
        check_field("status", e.status, out_if.status);
        check_field("last", e.last, out_if.last);
      end
    end
  end

  task automatic add_cmd(kmst_cmd_t cmd, int a = 0, int b = 0, logic [31:0] len = 0,
                         bit hold = 0);
    edge_cmd_t c;
    c.cmd = cmd; c.a = a[5:0]; c.b = b[5:0]; c.len = len; c.hold = hold;
    pending_cmds.push_back(c);
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || tree_results_due.size() > 0 || in_if.valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_vertex_total(int vc);
    wait_drained();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= vc[6:0];
    do @(posedge clk); while (!cfg_if.ready);
    vertex_total = vc;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_len();
    case ($urandom_range(5))
      0, 1: return $urandom_range(7);
      2:    return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // clear (usually), load a graph, run; mostly ends inside the vertex range
  task automatic add_graph(int nloads);
    int hi;
    hi = (vertex_total < 2 || vertex_total > 64) ? 63 : vertex_total - 1;
    if ($urandom_range(3) != 0) add_cmd(CMD_CLEAR);
    for (int k = 0; k < nloads; k++) begin
      if ($urandom_range(4) == 0)
        add_cmd(CMD_LOAD, $urandom_range(63), $urandom_range(63), pick_len());
      else
        add_cmd(CMD_LOAD, $urandom_range(hi), $urandom_range(hi), pick_len());
      if ($urandom_range(19) == 0) add_cmd(CMD_NOP, $urandom_range(63), 0, $urandom);
    end
    add_cmd(CMD_RUN, 0, 0, 0, $urandom_range(9) == 0);
    if ($urandom_range(5) == 0) add_cmd(CMD_RUN);
  endtask

  initial begin
    int vcs[8] = '{5, 64, 2, 127, 12, 0, 33, 1};
    in_if.valid = 1'b0; in_if.cmd = CMD_NOP; in_if.end_a = '0; in_if.end_b = '0;
    in_if.length = '0; out_if.ready = 1'b0; cfg_if.valid = 1'b0; cfg_if.data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: empty trees, extremes, ties, exhaustion, unused command
    write_vertex_total(0);
    add_cmd(CMD_RUN);
    write_vertex_total(1);
    add_cmd(CMD_LOAD, 0, 1, 5);
    add_cmd(CMD_RUN);
    write_vertex_total(4);
    add_cmd(CMD_CLEAR);
    add_cmd(CMD_LOAD, 63, 0, 32'hFFFF_FFFF);
    add_cmd(CMD_LOAD, 0, 1, 32'h0001_0000);
    add_cmd(CMD_LOAD, 1, 2, 32'h0001_0000);
    add_cmd(CMD_LOAD, 2, 1, 32'h0001_0000);
    add_cmd(CMD_LOAD, 3, 3, 0);
    add_cmd(CMD_NOP, 63, 63, 32'hFFFF_FFFF);
    add_cmd(CMD_LOAD, 2, 3, 0);
    add_cmd(CMD_RUN);
    add_cmd(CMD_RUN);
    add_cmd(CMD_CLEAR);
    add_cmd(CMD_LOAD, 0, 1, 7);
    add_cmd(CMD_LOAD, 1, 0, 3);
    add_cmd(CMD_RUN, 0, 0, 0, 1);
    write_vertex_total(64);
    add_cmd(CMD_RUN);

    // store full, then one run over the full store
    add_cmd(CMD_CLEAR);
    for (int k = 0; k < MAX_EDGES_DEF + 2; k++)
      add_cmd(CMD_LOAD, $urandom_range(63), $urandom_range(63), pick_len());
    add_cmd(CMD_RUN);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      write_vertex_total(vcs[ph]);
      idle_mode = ph % 4;
      for (int g = 0; g < 2; g++)
        add_graph($urandom_range(1, 6));
    end
    write_vertex_total(127);
    idle_mode = 0;
    add_graph(20);

    wait_drained();
    repeat (50) @(posedge clk);
    if (fails == 0) $display("kruskal_minimum_spanning_tree_unit_test OK");
    else $display("kruskal_minimum_spanning_tree_unit_test NOT OK");
    $finish;
  end

endmodule
